FILE: hdl/rmfa_pkg.sv
// Shared types and codes for the recursive mutex arbiter.
package rmfa_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  localparam logic [1:0] ACT_LOCK   = 2'd0;
  localparam logic [1:0] ACT_TRY    = 2'd1;
  localparam logic [1:0] ACT_UNLOCK = 2'd2;

  localparam logic [3:0] ST_GRANTED   = 4'd0;
  localparam logic [3:0] ST_QUEUED    = 4'd1;
  localparam logic [3:0] ST_BUSY      = 4'd2;
  localparam logic [3:0] ST_FREED     = 4'd3;
  localparam logic [3:0] ST_HANDED    = 4'd4;
  localparam logic [3:0] ST_STILL     = 4'd5;
  localparam logic [3:0] ST_NOT_OWNER = 4'd6;
  localparam logic [3:0] ST_QFULL     = 4'd7;
  localparam logic [3:0] ST_DFULL     = 4'd8;

  // queue operation from the controller
  typedef struct packed {
    logic shift;  // pop head, every cell takes its right neighbor
    logic enq;    // write requester at the tail
    logic inc;    // raise depth of the first matching waiter
  } queue_cmd_t;

  // per-cell operation
  typedef struct packed {
    logic shift;
    logic load;
    logic inc;
    logic occ;
  } cell_cmd_t;

endpackage

FILE: hdl/rmfa_cell.sv
// One waiter slot: id, pending depth, match flag and first-match chain.
module rmfa_cell import rmfa_pkg::*; #(
  parameter int ID_BITS    = 8,
  parameter int DEPTH_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic [ID_BITS-1:0]    req_id,
  input  logic [ID_BITS-1:0]    nbr_id,
  input  logic [DEPTH_BITS-1:0] nbr_depth,
  input  logic                  seen_in,
  output logic                  seen_out,
  output logic [ID_BITS-1:0]    id,
  output logic [DEPTH_BITS-1:0] depth,
  output logic [DEPTH_BITS-1:0] sel_depth
);

  logic hit;
  logic first;

  assign first     = hit && !seen_in;
  assign seen_out  = seen_in || hit;
  assign sel_depth = first ? depth : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= cmd.occ && (id == req_id);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      id    <= nbr_id;
      depth <= nbr_depth;
    end else if (cmd.load) begin
      id    <= req_id;
      depth <= DEPTH_BITS'(1);
    end else if (cmd.inc && first) begin
      depth <= depth + DEPTH_BITS'(1);
    end
  end

endmodule

FILE: hdl/rmfa_queue.sv
// Row of waiter cells forming the FIFO; head at cell 0.
module rmfa_queue import rmfa_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int DEPTH_BITS  = 8,
  parameter int CW          = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  queue_cmd_t            cmd,
  input  logic [CW-1:0]         count,
  input  logic [ID_BITS-1:0]    req_id,
  output logic [ID_BITS-1:0]    head_id,
  output logic [DEPTH_BITS-1:0] head_depth,
  output logic                  any_hit,
  output logic [DEPTH_BITS-1:0] hit_depth
);

  logic [ID_BITS-1:0]    ids    [QUEUE_DEPTH+1];
  logic [DEPTH_BITS-1:0] depths [QUEUE_DEPTH+1];
  logic [DEPTH_BITS-1:0] sel    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]  seen;

  assign ids[QUEUE_DEPTH]    = '0;
  assign depths[QUEUE_DEPTH] = '0;
  assign seen[0]             = 1'b0;
  assign any_hit             = seen[QUEUE_DEPTH];
  assign head_id             = ids[0];
  assign head_depth          = depths[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_cmd_t ccmd;
    assign ccmd.shift = cmd.shift;
    assign ccmd.load  = cmd.enq && (count == CW'(i));
    assign ccmd.inc   = cmd.inc;
    assign ccmd.occ   = CW'(i) < count;

    rmfa_cell #(
      .ID_BITS    (ID_BITS),
      .DEPTH_BITS (DEPTH_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (ccmd),
      .req_id    (req_id),
      .nbr_id    (ids[i+1]),
      .nbr_depth (depths[i+1]),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .id        (ids[i]),
      .depth     (depths[i]),
      .sel_depth (sel[i])
    );
  end

  // at most one cell is the first match, so an OR picks its depth
  always_comb begin
    hit_depth = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_depth = hit_depth | sel[i];
    end
  end

endmodule

FILE: hdl/recursive_mutex_fifo_arbiter.sv
// Top level: hardware mutex with owner tracking, recursion and a FIFO of waiters.
//
// Usage:
//   Request channel: drive action and requester_id with start high; the
//   transaction is taken at a rising edge where start is high and busy low.
//   Result channel: done pulses for one cycle with status, owner_valid,
//   owner_id and hold_depth. The receiver cannot stall; a result is
//   presented once and must be captured in that cycle.
//   Config: cfg_write with cfg_data[0] sets recursive_mode; write it only
//   while the block is idle. It applies to the next transaction.
// Timing:
//   An accepted transaction passes through the match state, where each waiter
//   cell registers its id compare, and the apply state, which resolves the first
//   match along the cell chain and updates owner and queue. done is registered
//   from the apply state; busy is high during match and apply, so a new
//   transaction is accepted at the edge that ends its predecessor's result cycle.
// Reset:
//   rst (synchronous) frees the mutex, empties the queue and clears
//   recursive_mode. Waiter slots hold stale data; only occupied slots count.
module recursive_mutex_fifo_arbiter import rmfa_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int DEPTH_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action,
  input  logic [ID_BITS-1:0]    requester_id,
  input  logic                  cfg_write,
  input  logic                  cfg_data,
  output logic                  done,
  output logic [3:0]            status,
  output logic                  owner_valid,
  output logic [ID_BITS-1:0]    owner_id,
  output logic [DEPTH_BITS-1:0] hold_depth
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  state_t state, state_next;

  logic [1:0]            req_action;
  logic [ID_BITS-1:0]    req_id;
  logic                  mode;
  logic                  owner_held, owner_held_next;
  logic [ID_BITS-1:0]    owner_reg, owner_reg_next;
  logic [DEPTH_BITS-1:0] depth_reg, depth_reg_next;
  logic [CW-1:0]         count, count_next;
  logic [3:0]            st_next;
  logic                  done_next;

  queue_cmd_t            qcmd;
  logic [ID_BITS-1:0]    head_id;
  logic [DEPTH_BITS-1:0] head_depth;
  logic                  any_hit;
  logic [DEPTH_BITS-1:0] hit_depth;

  logic owner_is_req;
  logic queue_full;

  assign busy         = (state != S_IDLE);
  assign owner_is_req = owner_held && (owner_reg == req_id);
  assign queue_full   = (count == CW'(QUEUE_DEPTH));

  rmfa_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .DEPTH_BITS  (DEPTH_BITS),
    .CW          (CW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .cmd        (qcmd),
    .count      (count),
    .req_id     (req_id),
    .head_id    (head_id),
    .head_depth (head_depth),
    .any_hit    (any_hit),
    .hit_depth  (hit_depth)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture; stable through the match and apply cycles
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_action <= action;
      req_id     <= requester_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      owner_held <= 1'b0;
      owner_reg  <= '0;
      depth_reg  <= '0;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_data;
      end
      owner_held <= owner_held_next;
      owner_reg  <= owner_reg_next;
      depth_reg  <= depth_reg_next;
      count      <= count_next;
      done       <= done_next;
    end
  end

  // result fields only matter while done is high
  always_ff @(posedge clk) begin
    if (done_next) begin
      status      <= st_next;
      owner_valid <= owner_held_next;
      owner_id    <= owner_held_next ? owner_reg_next : '0;
      hold_depth  <= owner_held_next ? depth_reg_next : '0;
    end
  end

  always_comb begin
    state_next      = state;
    owner_held_next = owner_held;
    owner_reg_next  = owner_reg;
    depth_reg_next  = depth_reg;
    count_next      = count;
    st_next         = ST_BUSY;
    done_next       = 1'b0;
    qcmd            = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        // cells register their id compare this cycle
        state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        case (req_action)
          ACT_LOCK: begin
            if (!owner_held) begin
              owner_held_next = 1'b1;
              owner_reg_next  = req_id;
              depth_reg_next  = DEPTH_BITS'(1);
              st_next         = ST_GRANTED;
            end else if (mode && owner_is_req) begin
              if (depth_reg == DEPTH_MAX) begin
                st_next = ST_DFULL;
              end else begin
                depth_reg_next = depth_reg + DEPTH_BITS'(1);
                st_next        = ST_GRANTED;
              end
            end else if (mode && any_hit) begin
              // already waiting: deepen the earliest entry for this id
              if (hit_depth == DEPTH_MAX) begin
                st_next = ST_DFULL;
              end else begin
                qcmd.inc = 1'b1;
                st_next  = ST_QUEUED;
              end
            end else if (queue_full) begin
              st_next = ST_QFULL;
            end else begin
              qcmd.enq   = 1'b1;
              count_next = count + CW'(1);
              st_next    = ST_QUEUED;
            end
          end
          ACT_TRY: begin
            if (mode && owner_is_req) begin
              if (depth_reg == DEPTH_MAX) begin
                st_next = ST_DFULL;
              end else begin
                depth_reg_next = depth_reg + DEPTH_BITS'(1);
                st_next        = ST_GRANTED;
              end
            end else if (owner_held) begin
              st_next = ST_BUSY;
            end else begin
              owner_held_next = 1'b1;
              owner_reg_next  = req_id;
              depth_reg_next  = DEPTH_BITS'(1);
              st_next         = ST_GRANTED;
            end
          end
          ACT_UNLOCK: begin
            if (!owner_is_req) begin
              st_next = ST_NOT_OWNER;
            end else if (mode && (depth_reg > DEPTH_BITS'(1))) begin
              depth_reg_next = depth_reg - DEPTH_BITS'(1);
              st_next        = ST_STILL;
            end else if (count != '0) begin
              // hand over to head waiter with its pending depth
              owner_reg_next = head_id;
              depth_reg_next = head_depth;
              qcmd.shift     = 1'b1;
              count_next     = count - CW'(1);
              st_next        = ST_HANDED;
            end else begin
              owner_held_next = 1'b0;
              owner_reg_next  = '0;
              depth_reg_next  = '0;
              st_next         = ST_FREED;
            end
          end
          default: begin
            st_next = ST_BUSY;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result strobe only right after the apply cycle
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_APPLY))
    else $error("done without apply cycle");

  // accepted transaction goes straight to the match cycle
  a_accept_to_match: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_MATCH))
    else $error("accepted transaction did not enter match");

  // a held mutex always has a nonzero depth
  a_held_depth: assert property (@(posedge clk) disable iff (rst)
    owner_held |-> (depth_reg != '0))
    else $error("mutex held with zero depth");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("waiter count beyond queue depth");

  // free mutex reports zero owner and depth
  a_free_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !owner_valid) |-> (owner_id == '0 && hold_depth == '0))
    else $error("free mutex with nonzero owner fields");

endmodule
